### hdl/fgbb_pkg.sv
// Shared types, constants and helpers for the foreground bounding box block.
package fgbb_pkg;

  localparam int COORD_W  = 12;
  localparam int CHAN_W   = 8;
  localparam int LWIDTH_W = 13;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_TOLERANCE = 1'd1;

  localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RESET       = 13'd640;
  localparam logic [CHAN_W-1:0]   COLOUR_TOLERANCE_RESET = 8'd10;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] y_max;
  } result_t;

  // True when two channel values differ by more than the tolerance.
  function automatic logic chan_exceeds(input logic [CHAN_W-1:0] a,
                                        input logic [CHAN_W-1:0] b,
                                        input logic [CHAN_W-1:0] tol);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > tol;
  endfunction

endpackage

### hdl/fgbb_in_reg.sv
// Input register stage: holds one pixel until the tracker consumes it.
module fgbb_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [23:0]     s_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic            s_tlast,   // frame_end
  input  logic            advance,
  output logic            p_valid,
  output fgbb_pkg::pixel_t p_pix
);

  assign s_tready = !p_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_tready) begin
      p_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      p_pix.red       <= s_tdata[7:0];
      p_pix.green     <= s_tdata[15:8];
      p_pix.blue      <= s_tdata[23:16];
      p_pix.frame_end <= s_tlast;
    end
  end

endmodule

### hdl/fgbb_tracker.sv
// Frame state, foreground test, box update and result register.
module fgbb_tracker #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [fgbb_pkg::LWIDTH_W-1:0]     line_width,
  input  logic [fgbb_pkg::CHAN_W-1:0]       colour_tolerance,
  input  logic                              p_valid,
  input  fgbb_pkg::pixel_t                  p_pix,
  output logic                              advance,
  output logic                              res_valid,
  input  logic                              res_ready,
  output fgbb_pkg::result_t                 res
);

  localparam int CW = $clog2(MAX_DIMENSION);
  localparam int BW = (CW > fgbb_pkg::COORD_W) ? CW : fgbb_pkg::COORD_W;
  localparam int EW = (CW + 1 > fgbb_pkg::LWIDTH_W) ? CW + 1 : fgbb_pkg::LWIDTH_W;
  localparam logic [BW-1:0] BOX_LOW_RESET = BW'(12'hFFF);

  logic [CW-1:0]                 column_count, column_count_next;
  logic [CW-1:0]                 row_count, row_count_next;
  logic [3*fgbb_pkg::CHAN_W-1:0] background_colour;
  logic                          first_pixel_pending;
  logic                          any_foreground, any_foreground_next;
  logic [BW-1:0]                 box_left, box_left_next;
  logic [BW-1:0]                 box_right, box_right_next;
  logic [BW-1:0]                 box_top, box_top_next;
  logic [BW-1:0]                 box_bottom, box_bottom_next;

  logic [3*fgbb_pkg::CHAN_W-1:0] bg_eff;
  logic                          is_fg;
  logic [EW-1:0]                 width_eff;
  logic                          wrap;
  logic [BW-1:0]                 col_b, row_b;
  fgbb_pkg::result_t             res_next;

  // Non-final pixels never need the result register.
  assign advance = p_valid && (!p_pix.frame_end || !res_valid || res_ready);

  always_comb begin
    // first pixel of a frame is its own background
    bg_eff = first_pixel_pending ? {p_pix.red, p_pix.green, p_pix.blue} : background_colour;
    is_fg = fgbb_pkg::chan_exceeds(p_pix.red,   bg_eff[23:16], colour_tolerance) ||
            fgbb_pkg::chan_exceeds(p_pix.green, bg_eff[15:8],  colour_tolerance) ||
            fgbb_pkg::chan_exceeds(p_pix.blue,  bg_eff[7:0],   colour_tolerance);

    // clamp line width to [1, MAX_DIMENSION]
    width_eff = EW'(line_width);
    if (width_eff == '0) begin
      width_eff = EW'(1);
    end else if (width_eff > EW'(MAX_DIMENSION)) begin
      width_eff = EW'(MAX_DIMENSION);
    end

    col_b = BW'(column_count);
    row_b = BW'(row_count);

    any_foreground_next = any_foreground || is_fg;
    box_left_next   = box_left;
    box_right_next  = box_right;
    box_top_next    = box_top;
    box_bottom_next = box_bottom;
    if (is_fg) begin
      if (col_b < box_left)   box_left_next   = col_b;
      if (col_b > box_right)  box_right_next  = col_b;
      if (row_b < box_top)    box_top_next    = row_b;
      if (row_b > box_bottom) box_bottom_next = row_b;
    end

    wrap = (EW'(column_count) + EW'(1)) >= width_eff;
    column_count_next = wrap ? '0 : column_count + CW'(1);
    row_count_next = row_count;
    if (wrap && ((EW'(row_count) + EW'(1)) < EW'(MAX_DIMENSION))) begin
      row_count_next = row_count + CW'(1);
    end

    res_next.found = any_foreground_next;
    if (any_foreground_next) begin
      res_next.x_min = box_left_next[fgbb_pkg::COORD_W-1:0];
      res_next.x_max = box_right_next[fgbb_pkg::COORD_W-1:0];
      res_next.y_min = box_top_next[fgbb_pkg::COORD_W-1:0];
      res_next.y_max = box_bottom_next[fgbb_pkg::COORD_W-1:0];
    end else begin
      res_next.x_min = '0;
      res_next.x_max = '0;
      res_next.y_min = '0;
      res_next.y_max = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count        <= '0;
      row_count           <= '0;
      background_colour   <= '0;
      first_pixel_pending <= 1'b1;
      any_foreground      <= 1'b0;
      box_left            <= BOX_LOW_RESET;
      box_right           <= '0;
      box_top             <= BOX_LOW_RESET;
      box_bottom          <= '0;
    end else if (advance) begin
      if (p_pix.frame_end) begin
        // frame done: back to the cleared state
        column_count        <= '0;
        row_count           <= '0;
        background_colour   <= '0;
        first_pixel_pending <= 1'b1;
        any_foreground      <= 1'b0;
        box_left            <= BOX_LOW_RESET;
        box_right           <= '0;
        box_top             <= BOX_LOW_RESET;
        box_bottom          <= '0;
      end else begin
        column_count        <= column_count_next;
        row_count           <= row_count_next;
        background_colour   <= bg_eff;
        first_pixel_pending <= 1'b0;
        any_foreground      <= any_foreground_next;
        box_left            <= box_left_next;
        box_right           <= box_right_next;
        box_top             <= box_top_next;
        box_bottom          <= box_bottom_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && p_pix.frame_end) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && p_pix.frame_end) begin
      res <= res_next;
    end
  end

endmodule

### hdl/foreground_bounding_box.sv
// Foreground bounding box: top level with config registers and stream ports.
// Pipeline: two-deep (input register, result register); the tracker processes the pixel
//   in the input register; a frame end fills the result register on the master side.
// Throughput: one pixel per cycle sustained; only a frame-end pixel can wait on
//   an untaken result, ordinary pixels pass the result register freely.
// Reset: synchronous active-high rst clears the frame state, the valid flags and
//   restores line_width to 640 and colour_tolerance to 10.
module foreground_bounding_box #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fgbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fgbb_pkg::LWIDTH_W-1:0]      cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [23:0]                        s_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic                               s_tlast,   // frame_end
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [47:0]                        m_tdata,   // x_min [11:0], x_max [23:12],
                                                        // y_min [35:24], y_max [47:36]
  output logic                               m_tuser    // found
);

  logic [fgbb_pkg::LWIDTH_W-1:0] line_width;
  logic [fgbb_pkg::CHAN_W-1:0]   colour_tolerance;

  logic              p_valid;
  fgbb_pkg::pixel_t  p_pix;
  logic              advance;
  fgbb_pkg::result_t res;

  // Configuration registers; to be written only while the block is idle (the block itself does not enforce this).
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width       <= fgbb_pkg::LINE_WIDTH_RESET;
      colour_tolerance <= fgbb_pkg::COLOUR_TOLERANCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fgbb_pkg::CFG_LINE_WIDTH:       line_width       <= cfg_data;
        fgbb_pkg::CFG_COLOUR_TOLERANCE: colour_tolerance <= cfg_data[fgbb_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  fgbb_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .p_valid  (p_valid),
    .p_pix    (p_pix)
  );

  fgbb_tracker #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_tracker (
    .clk              (clk),
    .rst              (rst),
    .line_width       (line_width),
    .colour_tolerance (colour_tolerance),
    .p_valid          (p_valid),
    .p_pix            (p_pix),
    .advance          (advance),
    .res_valid        (m_tvalid),
    .res_ready        (m_tready),
    .res              (res)
  );

  assign m_tuser = res.found;
  assign m_tdata = {res.y_max, res.y_min, res.x_max, res.x_min};

  // A new result transaction only comes from a frame-end pixel leaving the input stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(p_valid && p_pix.frame_end && advance))
    else $error("result appeared without a frame-end pixel");

  // An empty frame reports an all-zero box.
  a_empty_box_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("empty frame reported a nonzero box");

  // A found box is ordered when coordinates fit the reported width.
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && (MAX_DIMENSION <= 4096)) |->
      ((res.x_min <= res.x_max) && (res.y_min <= res.y_max)))
    else $error("reported box is inverted");

  // Input stalls only while the input register holds a pixel that cannot move.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (p_valid && p_pix.frame_end && m_tvalid && !m_tready))
    else $error("input stalled without a blocked frame-end pixel");

endmodule

### tb/sv/tb_foreground_bounding_box.sv
// Self-checking testbench for the foreground bounding box block.
module tb_foreground_bounding_box;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM        = 4096;
  localparam int DRAIN_CYCLES   = 8;     // input reg + result reg, with margin
  localparam int RX_HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction at all
  localparam int RANDOM_PIXELS  = 1780;

  // How a random channel value relates to the background.
  typedef enum int {LVL_NEAR, LVL_BORDER, LVL_ANY} level_mode_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_we    = 1'b0;
  logic [fgbb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fgbb_pkg::LWIDTH_W-1:0]  cfg_data  = '0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [23:0]                    s_tdata   = '0;   // red [7:0], green [15:8], blue [23:16]
  logic                           s_tlast   = 1'b0; // frame_end
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [47:0]                    m_tdata;          // x_min [11:0], x_max [23:12],
                                                    // y_min [35:24], y_max [47:36]
  logic                           m_tuser;          // found

  always #6 clk = ~clk;

  foreground_bounding_box #(
    .MAX_DIMENSION(MAX_DIM)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  int                 errors       = 0;
  int                 sent_pixels  = 0;
  int                 quiet_cycles = 0;
  bit                 tx_gap_en    = 1'b1;  // sender inserts random gaps
  bit                 rx_stall_en  = 1'b1;  // receiver drops tready at random
  bit                 rx_hold_req  = 1'b0;  // one long hold-off, cleared by the sink
  fgbb_pkg::result_t  expected_boxes[$];    // boxes still owed by the block

  // Box tracker: settings as the block holds them, plus the frame state.
  logic [fgbb_pkg::LWIDTH_W-1:0] lw_cfg  = fgbb_pkg::LINE_WIDTH_RESET;
  logic [fgbb_pkg::CHAN_W-1:0]   tol_cfg = fgbb_pkg::COLOUR_TOLERANCE_RESET;
  int                            col_pos, row_pos;
  logic [fgbb_pkg::CHAN_W-1:0]   bg_r, bg_g, bg_b;
  bit                            bg_pending;
  bit                            fg_seen;
  int                            min_col, max_col, min_row, max_row;

  function automatic void clear_tracker();
    col_pos    = 0;
    row_pos    = 0;
    bg_r       = '0;
    bg_g       = '0;
    bg_b       = '0;
    bg_pending = 1'b1;
    fg_seen    = 1'b0;
    min_col    = MAX_DIM - 1;
    max_col    = 0;
    min_row    = MAX_DIM - 1;
    max_row    = 0;
  endfunction

  function automatic bit channel_off(input logic [fgbb_pkg::CHAN_W-1:0] a,
                                     input logic [fgbb_pkg::CHAN_W-1:0] b);
    int d;
    d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d > int'(tol_cfg);
  endfunction

  // Advance the tracker by one accepted pixel; a frame end owes one box.
  function automatic void track_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic last);
    int                width;
    fgbb_pkg::result_t box;
    width = int'(lw_cfg);
    if (width == 0) width = 1;
    if (width > MAX_DIM) width = MAX_DIM;
    // first pixel of a frame defines the background, so it never counts
    if (bg_pending) begin
      bg_r       = r;
      bg_g       = g;
      bg_b       = b;
      bg_pending = 1'b0;
    end
    if (channel_off(r, bg_r) || channel_off(g, bg_g) || channel_off(b, bg_b)) begin
      fg_seen = 1'b1;
      if (col_pos < min_col) min_col = col_pos;
      if (col_pos > max_col) max_col = col_pos;
      if (row_pos < min_row) min_row = row_pos;
      if (row_pos > max_row) max_row = row_pos;
    end
    // raster advance; the row counter sticks at the last row
    if (col_pos + 1 >= width) begin
      col_pos = 0;
      if (row_pos + 1 < MAX_DIM) row_pos++;
    end else begin
      col_pos++;
    end
    if (last) begin
      box = '0;
      if (fg_seen) begin
        box.found = 1'b1;
        box.x_min = 12'(min_col);
        box.x_max = 12'(max_col);
        box.y_min = 12'(min_row);
        box.y_max = 12'(max_row);
      end
      expected_boxes = {expected_boxes, box};
      clear_tracker();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Gap lengths: mostly none, some short, a few long
  // ---------------------------------------------------------------------------
  function automatic int tx_gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gap_en || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int rx_stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (!rx_stall_en || r < 80) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Offer one pixel; returns in the step of its transaction with tvalid still
  // high, so a back-to-back pixel only changes the data.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
    int gap;
    gap = tx_gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_pixel(r, g, b, last);
    sent_pixels++;
  endtask

  // Stop offering, let every owed box arrive, then let the pipe empty out
  // (pixels without frame end leave nothing to wait for).
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only called with the block drained.
  task automatic reg_write(input logic [fgbb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fgbb_pkg::LWIDTH_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    if (idx == fgbb_pkg::CFG_LINE_WIDTH) lw_cfg = data;
    else if (idx == fgbb_pkg::CFG_COLOUR_TOLERANCE) tol_cfg = data[fgbb_pkg::CHAN_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_level(input logic [7:0] base,
                                            input level_mode_t mode);
    int off, v;
    case (mode)
      LVL_NEAR:   off = $urandom_range(0, int'(tol_cfg));
      LVL_BORDER: off = int'(tol_cfg) + $urandom_range(0, 1);
      default:    return 8'($urandom_range(0, 255));
    endcase
    v = $urandom_range(0, 1) ? int'(base) + off : int'(base) - off;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] pick_background();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame of npix pixels: background first, then a mix of near-background
  // pixels and pixels on or past the tolerance border.
  task automatic send_random_frame(input int npix, input int fg_pct);
    logic [7:0]  br, bgr, bb, r, g, b;
    level_mode_t mode;
    br  = pick_background();
    bgr = pick_background();
    bb  = pick_background();
    send_pixel(br, bgr, bb, npix == 1);
    for (int i = 1; i < npix; i++) begin
      mode = LVL_NEAR;
      if ($urandom_range(0, 99) < fg_pct)
        mode = $urandom_range(0, 1) ? LVL_BORDER : LVL_ANY;
      r = pick_level(br, mode);
      g = pick_level(bgr, $urandom_range(0, 2) == 0 ? mode : LVL_NEAR);
      b = pick_level(bb, $urandom_range(0, 2) == 0 ? mode : LVL_NEAR);
      send_pixel(r, g, b, i == npix - 1);
    end
  endtask

  task automatic randomize_settings();
    int                            r;
    logic [fgbb_pkg::LWIDTH_W-1:0] w, t;
    drain_pipeline();
    r = $urandom_range(0, 99);
    if (r < 70) w = 13'($urandom_range(1, 16));
    else if (r < 90) w = 13'($urandom_range(17, 200));
    else begin
      case ($urandom_range(0, 3))
        0:       w = 13'd0;
        1:       w = 13'd4096;
        2:       w = 13'h1fff;
        default: w = 13'($urandom_range(0, 8191));
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 50) t = 13'($urandom_range(0, 24));
    else if (r < 62) t = $urandom_range(0, 1) ? 13'd0 : 13'd255;
    else t = 13'($urandom_range(0, 255));
    // bits above the tolerance width are don't-care for that register
    if ($urandom_range(0, 2) == 0) t[12:8] = 5'($urandom_range(0, 31));
    reg_write(fgbb_pkg::CFG_LINE_WIDTH, w);
    reg_write(fgbb_pkg::CFG_COLOUR_TOLERANCE, t);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings (640 wide, tolerance 10); first pixel is never foreground.
  task automatic test_reset_defaults();
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);         // lone pixel: nothing found
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h0a, 8'h00, 8'h00, 1'b0);         // diff == tolerance: background
    send_pixel(8'h0b, 8'h00, 8'h00, 1'b0);         // col 2
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
  endtask

  task automatic test_channel_extremes();
    drain_pipeline();
    reg_write(fgbb_pkg::CFG_LINE_WIDTH, 13'd2);
    reg_write(fgbb_pkg::CFG_COLOUR_TOLERANCE, 13'd0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hfe, 1'b0);         // blue off by one
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'h00, 8'hff, 8'hff, 1'b0);         // red at the far end
    send_pixel(8'hff, 8'h00, 8'hff, 1'b1);         // green at the far end
  endtask

  task automatic test_tolerance_bounds();
    drain_pipeline();
    reg_write(fgbb_pkg::CFG_COLOUR_TOLERANCE, 13'd255);  // nothing can be foreground
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    drain_pipeline();
    reg_write(fgbb_pkg::CFG_COLOUR_TOLERANCE, 13'h1f0a); // upper bits ignored -> 10
    reg_write(fgbb_pkg::CFG_LINE_WIDTH, 13'd3);
    send_pixel(8'h14, 8'h14, 8'h14, 1'b0);
    send_pixel(8'h1e, 8'h1e, 8'h1e, 1'b0);
    send_pixel(8'h14, 8'h1f, 8'h14, 1'b0);
    send_pixel(8'h0a, 8'h0a, 8'h0a, 1'b1);
  endtask

  // Width 0 behaves like width 1: every pixel starts a new row.
  task automatic test_zero_line_width();
    drain_pipeline();
    reg_write(fgbb_pkg::CFG_LINE_WIDTH, 13'd0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h80, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
  endtask

  // Settings changed inside a frame apply from the next pixel on.
  task automatic test_mid_frame_change();
    drain_pipeline();
    reg_write(fgbb_pkg::CFG_LINE_WIDTH, 13'd4);
    send_pixel(8'h40, 8'h40, 8'h40, 1'b0);
    send_pixel(8'h40, 8'h40, 8'h40, 1'b0);
    send_pixel(8'h40, 8'h90, 8'h40, 1'b0);         // col 2 row 0
    drain_pipeline();
    reg_write(fgbb_pkg::CFG_LINE_WIDTH, 13'd2);    // column 3 is past the new width
    send_pixel(8'h40, 8'h40, 8'hc0, 1'b0);         // col 3, then wraps
    send_pixel(8'h40, 8'h40, 8'h40, 1'b0);
    drain_pipeline();
    reg_write(fgbb_pkg::CFG_COLOUR_TOLERANCE, 13'd255);
    send_pixel(8'hff, 8'h00, 8'hff, 1'b1);         // would be foreground before
  endtask

  // Receiver holds off; frame ends pile up until the input stalls.
  task automatic test_output_backpressure();
    drain_pipeline();
    reg_write(fgbb_pkg::CFG_COLOUR_TOLERANCE, 13'd10);
    tx_gap_en   = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_pixel(8'(i * 3), 8'h20, 8'h20, 1'b0);
      send_pixel(8'(255 - i * 5), 8'h20, 8'(i), 1'b1);
    end
    tx_gap_en = 1'b1;
    drain_pipeline();
  endtask

  task automatic test_random_frames();
    int start, npix;
    start = sent_pixels;
    while (sent_pixels - start < RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) == 0) randomize_settings();
      tx_gap_en   = ($urandom_range(0, 4) != 0);
      rx_stall_en = ($urandom_range(0, 4) != 0);
      npix = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 300)
                                         : $urandom_range(1, 48);
      send_random_frame(npix, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 40));
    end
    tx_gap_en   = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  // Width above the limit is clamped: a short frame stays on row 0.
  task automatic test_wide_line_clamp();
    drain_pipeline();
    reg_write(fgbb_pkg::CFG_COLOUR_TOLERANCE, 13'd0);
    reg_write(fgbb_pkg::CFG_LINE_WIDTH, 13'h1fff);
    for (int i = 0; i < 6; i++)
      send_pixel(8'h00, (i == 5) ? 8'h01 : 8'h00, 8'h00, i == 5);
    drain_pipeline();
    reg_write(fgbb_pkg::CFG_LINE_WIDTH, 13'd4096);
    send_pixel(8'h10, 8'h10, 8'h10, 1'b0);
    send_pixel(8'h10, 8'h10, 8'h11, 1'b0);
    send_pixel(8'h10, 8'h10, 8'h10, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random tready with one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        m_tready <= 1'b1;
      end else begin
        stall = rx_stall_len();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each output transaction against the oldest owed box
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  fgbb_pkg::result_t want_box;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_boxes.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual found=%0d data=%h",
                 $time, m_tuser, m_tdata);
      end else begin
        want_box = expected_boxes.pop_front();
        check_field("found", want_box.found, m_tuser);
        check_field("x_min", want_box.x_min, m_tdata[11:0]);
        check_field("x_max", want_box.x_max, m_tdata[23:12]);
        check_field("y_min", want_box.y_min, m_tdata[35:24]);
        check_field("y_max", want_box.y_max, m_tdata[47:36]);
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_tracker();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_channel_extremes();
    test_tolerance_bounds();
    test_zero_line_width();
    test_mid_frame_change();
    test_output_backpressure();
    test_random_frames();
    test_wide_line_clamp();

    drain_pipeline();
    if (expected_boxes.size() != 0) errors += expected_boxes.size();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### foreground_bounding_box.f
hdl/fgbb_pkg.sv
hdl/fgbb_in_reg.sv
hdl/fgbb_tracker.sv
hdl/foreground_bounding_box.sv
tb/sv/tb_foreground_bounding_box.sv
